[design/tea_pkg.sv]
// Shared constants, types and round-sum helper for the TEA block cipher core.
// Used by tea_cell and tea_block_cipher_core; no dependencies.
`default_nettype none

package tea_pkg;

	localparam int unsigned KEY_BYTES   = 16;
	localparam int unsigned KEY_WORDS   = KEY_BYTES / 4;
	localparam int unsigned KEY_IDX_W   = $clog2(KEY_WORDS);
	localparam int unsigned ROUNDS      = 32;
	localparam int unsigned HALF_ROUNDS = 2 * ROUNDS;
	localparam logic [31:0] DELTA       = 32'h9e37_79b9;

	// Request type codes
	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	// Key words, index 0 in the low slot
	typedef logic [KEY_WORDS-1:0][31:0] key_t;

	// Block state carried from cell to cell
	typedef struct packed {
		logic        decrypt;
		logic [31:0] v0;
		logic [31:0] v1;
	} blk_t;

	// Running sum for a given multiple of delta, wrapped to 32 bits
	function automatic logic [31:0] round_sum(input int unsigned mult);
		logic [63:0] prod;
		prod = 64'(DELTA) * 64'(mult);
		return prod[31:0];
	endfunction

endpackage

`default_nettype wire

[design/tea_cell.sv]
// One Feistel half-round cell of the TEA pipeline with its stage register.
// Depends on tea_pkg for the block and key types.
`default_nettype none

module tea_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              phase,
	input  wire logic [31:0]       sum_enc,
	input  wire logic [31:0]       sum_dec,
	input  wire tea_pkg::key_t     key,
	input  wire logic              vld_in,
	input  wire tea_pkg::blk_t     blk_in,
	output logic                   vld_out,
	output tea_pkg::blk_t          blk_out
);

	logic          upd_v0;
	logic [31:0]   src;
	logic [31:0]   dst;
	logic [31:0]   ka;
	logic [31:0]   kb;
	logic [31:0]   sum;
	logic [31:0]   mix;
	logic [31:0]   upd;
	tea_pkg::blk_t nxt;
	logic          valid_s1;
	tea_pkg::blk_t blk_s1;

	// Pick which half is updated: encrypt updates v0 first, decrypt v1 first
	assign upd_v0 = ~(blk_in.decrypt ^ phase);
	assign src    = upd_v0 ? blk_in.v1 : blk_in.v0;
	assign dst    = upd_v0 ? blk_in.v0 : blk_in.v1;
	assign ka     = upd_v0 ? key[0] : key[2];
	assign kb     = upd_v0 ? key[1] : key[3];
	assign sum    = (blk_in.decrypt == tea_pkg::REQ_DECRYPT) ? sum_dec : sum_enc;

	// Round function, then add or subtract into the other half
	assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
	assign upd = (blk_in.decrypt == tea_pkg::REQ_DECRYPT) ? (dst - mix) : (dst + mix);

	always_comb begin
		nxt         = blk_in;
		if (upd_v0) begin
			nxt.v0 = upd;
		end else begin
			nxt.v1 = upd;
		end
	end

	// Hold the valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vld_in;
		end
	end

	// Advance the payload only with a live request
	always_ff @(posedge clk) begin
		if (en && vld_in) begin
			blk_s1 <= nxt;
		end
	end

	assign vld_out = valid_s1;
	assign blk_out = blk_s1;

endmodule

`default_nettype wire

[design/tea_out_buf.sv]
// Output register with a skid slot between the cipher pipeline and the result channel.
// Depends on nothing beyond plain logic; full flags the skid slot in use.
`default_nettype none

module tea_out_buf (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        arr_valid,
	input  wire logic [63:0] arr_block,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic [63:0]      block_out,
	output logic             full
);

	logic        out_valid_q;
	logic        skid_valid_q;
	logic [63:0] out_data_q;
	logic [63:0] skid_data_q;
	logic        take;

	assign take = out_valid_q && !out_stall;

	// Track occupancy of the output and skid slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (arr_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Move result data: drain skid first, else park or pass the arrival
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (arr_valid) begin
			if (!out_valid_q || take) begin
				out_data_q <= arr_block;
			end else begin
				skid_data_q <= arr_block;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign block_out = out_data_q;
	assign full      = skid_valid_q;

	// Skid slot is only used behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot occupied while output slot empty");

	// Skid slot fills only when the result was held the cycle before
	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid slot filled without a held result");

endmodule

`default_nettype wire

[design/tea_block_cipher_core.sv]
// TEA block cipher core: 64 half-round cells in a chain, one block per cycle while in_stall is low.
// A result passes through one cell per half-round, then the output register of tea_out_buf, before it is shown.
// Throughput: one request per cycle while in_stall is low; the 64-cell chain and output skid slot set this figure.
// Input stalls only while the skid slot holds a result behind a stalled output.
// Reset (arst_n low) empties the chain and output slots and clears all key words to zero.
// Depends on tea_pkg, tea_cell and tea_out_buf.
`default_nettype none

module tea_block_cipher_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [tea_pkg::KEY_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          req_type,
	input  wire logic [63:0]                   block_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [63:0]                        block_out
);

	tea_pkg::key_t                      key_q;
	logic [tea_pkg::HALF_ROUNDS-1:0]    stage_vld;
	tea_pkg::blk_t                      stage_blk [tea_pkg::HALF_ROUNDS];
	tea_pkg::blk_t                      head_blk;
	logic                               pipe_en;
	logic                               buf_full;

	// Write key words from the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr_en) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	// Split the incoming block into its halves, upper half first
	assign head_blk.decrypt = req_type;
	assign head_blk.v0      = block_in[63:32];
	assign head_blk.v1      = block_in[31:0];

	// Whole chain advances unless the skid slot is occupied
	assign pipe_en  = !buf_full;
	assign in_stall = buf_full;

	for (genvar k = 0; k < tea_pkg::HALF_ROUNDS; k++) begin : g_cell
		localparam logic [31:0] SUM_E = tea_pkg::round_sum(k / 2 + 1);
		localparam logic [31:0] SUM_D = tea_pkg::round_sum(tea_pkg::ROUNDS - k / 2);
		localparam logic        PHASE = 1'(k % 2);

		logic          vld_prev;
		tea_pkg::blk_t blk_prev;

		if (k == 0) begin : g_head
			assign vld_prev = in_valid;
			assign blk_prev = head_blk;
		end else begin : g_link
			assign vld_prev = stage_vld[k-1];
			assign blk_prev = stage_blk[k-1];
		end

		tea_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (pipe_en),
			.phase   (PHASE),
			.sum_enc (SUM_E),
			.sum_dec (SUM_D),
			.key     (key_q),
			.vld_in  (vld_prev),
			.blk_in  (blk_prev),
			.vld_out (stage_vld[k]),
			.blk_out (stage_blk[k])
		);
	end

	tea_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.arr_valid (pipe_en && stage_vld[tea_pkg::HALF_ROUNDS-1]),
		.arr_block ({stage_blk[tea_pkg::HALF_ROUNDS-1].v0,
		             stage_blk[tea_pkg::HALF_ROUNDS-1].v1}),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.block_out (block_out),
		.full      (buf_full)
	);

	// An accepted request lands in the first cell
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> stage_vld[0])
		else $error("accepted request missing from first cell");

	// A full skid slot freezes the whole chain
	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(stage_vld))
		else $error("cipher chain moved while output side was full");

endmodule

`default_nettype wire
